@@ sv/biu_pkg.sv @@
// Package with types, constants and helpers for the bilinear image upscaler.
package biu_pkg;

  localparam int unsigned MaxSourceWidth   = 64;
  localparam int unsigned MaxSourceHeight  = 64;
  localparam int unsigned RatioBits        = 15;
  localparam int unsigned TempFractionBits = 8;
  localparam int unsigned StoreDepth       = MaxSourceWidth * MaxSourceHeight;
  localparam int unsigned AddrW            = $clog2(StoreDepth);
  localparam int unsigned TargetMax        = 4096;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned CfgDataW         = 22;
  localparam int unsigned RatioW           = RatioBits + 1;
  localparam int unsigned TempW            = 8 + TempFractionBits;

  localparam logic [CfgIdxW-1:0] RegSourceWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSourceHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTargetWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTargetHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStepX        = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStepY        = 3'd5;

  localparam logic OpLoad = 1'b0;
  localparam logic OpEmit = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_b;
    logic [7:0] pixel_g;
    logic [7:0] pixel_r;
    logic [7:0] pixel_a;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_b;
    logic [7:0] out_g;
    logic [7:0] out_r;
    logic [7:0] out_a;
    logic       row_end;
    logic       frame_end;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle, StRd00, StRd01, StRd10, StRd11, StBlendH, StBlendV
  } state_e;

  typedef struct packed {
    logic load;
    logic map;
    logic [1:0] rd_sel;
    logic rd_en;
    logic hblend;
    logic vblend;
  } cmd_t;

  // Horizontal blend of one channel, rounded to a temporary.
  function automatic logic [TempW-1:0] hblend(input logic [7:0] p0, input logic [7:0] p1,
                                             input logic [RatioW-1:0] r);
    logic [RatioW+8:0] h;
    logic [RatioW+8:0] hr;
    h = (RatioW+9)'(p0) * (RatioW+9)'((RatioW)'(1 << RatioBits) - r)
        + (RatioW+9)'(p1) * (RatioW+9)'(r);
    hr = h + (RatioW+9)'(1 << (RatioBits - TempFractionBits - 1));
    return TempW'(hr >> (RatioBits - TempFractionBits));
  endfunction

  function automatic logic [7:0] vblend(input logic [TempW-1:0] t0, input logic [TempW-1:0] t1,
                                        input logic [RatioW-1:0] r);
    logic [TempW+RatioW:0] v;
    v = (TempW+RatioW+1)'(t0) * (TempW+RatioW+1)'((RatioW)'(1 << RatioBits) - r)
        + (TempW+RatioW+1)'(t1) * (TempW+RatioW+1)'(r)
        + (TempW+RatioW+1)'(1 << (RatioBits + TempFractionBits - 1));
    return v[RatioBits+TempFractionBits +: 8];
  endfunction

endpackage

@@ sv/biu_ctrl.sv @@
// Controller state machine of the bilinear image upscaler.
module biu_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  logic         opcode_i,
  output logic         busy,
  output biu_pkg::cmd_t cmd_o
);
  import biu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy = 1'b1;
    case (state_q)
      StIdle: begin
        busy = 1'b0;
        if (start) begin
          if (opcode_i == OpLoad) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.map = 1'b1;
            state_d = StRd00;
          end
        end
      end
      StRd00: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = 2'd0; state_d = StRd01;
      end
      StRd01: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = 2'd1; state_d = StRd10;
      end
      StRd10: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = 2'd2; state_d = StRd11;
      end
      StRd11: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = 2'd3; state_d = StBlendH;
      end
      StBlendH: begin
        cmd_o.hblend = 1'b1; state_d = StBlendV;
      end
      StBlendV: begin
        cmd_o.vblend = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

@@ sv/biu_datapath.sv @@
// Datapath of the bilinear image upscaler: frame store, positions and blending.
module biu_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  biu_pkg::cmd_t               cmd_i,
  input  biu_pkg::in_word_t           in_i,
  input  logic                        cfg_we_i,
  input  logic [biu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [biu_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                        res_valid_o,
  output biu_pkg::out_word_t          res_o
);
  import biu_pkg::*;

  logic [6:0]  sw_reg_q, sh_reg_q;
  logic [12:0] tw_reg_q, th_reg_q;
  logic [21:0] stx_q, sty_q;
  logic [12:0] sw, sh, tw, th;
  logic [12:0] count;
  logic [12:0] load_ptr_q;
  logic [11:0] col_q, row_q;
  logic signed [32:0] xpos_q, ypos_q;
  logic [31:0] store [StoreDepth];
  logic [AddrW-1:0] ix_q, iy_q, ixn, iyn;
  logic [RatioW-1:0] rx_q, ry_q, rxn, ryn;
  logic [AddrW-1:0] rd_addr;
  logic [31:0] rd_q;
  logic [1:0]  rd_sel_q;
  logic        rd_v_q;
  logic [31:0] w_q [4];
  logic [TempW-1:0] t0_q [4];
  logic [TempW-1:0] t1_q [4];
  logic rend_q, fend_q, rend, fend;
  logic [12:0] ptr_c, ptr_n;

  always_comb begin
    sw = (sw_reg_q < 7'd2) ? 13'd2 : (13'(sw_reg_q) > 13'(MaxSourceWidth) ?
          13'(MaxSourceWidth) : 13'(sw_reg_q));
    sh = (sh_reg_q < 7'd2) ? 13'd2 : (13'(sh_reg_q) > 13'(MaxSourceHeight) ?
          13'(MaxSourceHeight) : 13'(sh_reg_q));
    tw = (tw_reg_q < 13'd2) ? 13'd2 : (tw_reg_q > 13'(TargetMax) ?
          13'(TargetMax) : tw_reg_q);
    th = (th_reg_q < 13'd2) ? 13'd2 : (th_reg_q > 13'(TargetMax) ?
          13'(TargetMax) : th_reg_q);
    count = 13'(sw * sh);
    ptr_c = (load_ptr_q >= count) ? 13'd0 : load_ptr_q;
    ptr_n = (ptr_c + 13'd1 >= count) ? 13'd0 : ptr_c + 13'd1;
  end

  function automatic void map_pos(input logic signed [32:0] pos, input logic [12:0] size,
                                  output logic [AddrW-1:0] idx,
                                  output logic [RatioW-1:0] ratio);
    logic [32:0] last;
    logic [31:0] fr;
    last = {4'd0, size - 13'd1, 16'd0};
    if (pos < 0) begin
      idx = '0; ratio = '0;
    end else if ($unsigned(pos) >= last) begin
      idx = AddrW'(size - 13'd2); ratio = RatioW'(1 << RatioBits);
    end else begin
      idx = AddrW'(pos[32:16]);
      fr = ({16'd0, pos[15:0]} << RatioBits) + 32'h8000;
      ratio = RatioW'(fr >> 16);
    end
  endfunction

  always_comb begin
    map_pos(xpos_q, sw, ixn, rxn);
    map_pos(ypos_q, sh, iyn, ryn);
  end

  always_comb begin
    logic [AddrW+1:0] base;
    base = (AddrW+2)'(iy_q + AddrW'(cmd_i.rd_sel[1])) * (AddrW+2)'(sw) ;
    rd_addr = AddrW'(base + (AddrW+2)'(ix_q) + (AddrW+2)'(cmd_i.rd_sel[0]));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      store[AddrW'(ptr_c)] <= {in_i.pixel_a, in_i.pixel_r, in_i.pixel_g, in_i.pixel_b};
    end
    rd_q <= store[rd_addr];
    rd_sel_q <= cmd_i.rd_sel;
    if (cmd_i.map) begin
      ix_q <= ixn; rx_q <= rxn; iy_q <= iyn; ry_q <= ryn;
      rend_q <= rend; fend_q <= fend;
    end
    if (rd_v_q) begin
      w_q[rd_sel_q] <= rd_q;
    end
    if (cmd_i.hblend) begin
      for (int c = 0; c < 4; c++) begin
        t0_q[c] <= hblend(w_q[0][8*c +: 8], w_q[1][8*c +: 8], rx_q);
        t1_q[c] <= hblend(w_q[2][8*c +: 8], rd_q[8*c +: 8], rx_q);
      end
    end
    if (cmd_i.vblend) begin
      res_o.out_b <= vblend(t0_q[0], t1_q[0], ry_q);
      res_o.out_g <= vblend(t0_q[1], t1_q[1], ry_q);
      res_o.out_r <= vblend(t0_q[2], t1_q[2], ry_q);
      res_o.out_a <= vblend(t0_q[3], t1_q[3], ry_q);
      res_o.row_end <= rend_q;
      res_o.frame_end <= fend_q;
    end
  end

  assign rend = {1'b0, col_q} >= tw - 13'd1;
  assign fend = rend && ({1'b0, row_q} >= th - 13'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_reg_q <= 7'd64; sh_reg_q <= 7'd64;
      tw_reg_q <= 13'd128; th_reg_q <= 13'd128;
      stx_q <= 22'd32768; sty_q <= 22'd32768;
      load_ptr_q <= '0; col_q <= '0; row_q <= '0;
      xpos_q <= -33'sd32768; ypos_q <= -33'sd32768;
      rd_v_q <= 1'b0; res_valid_o <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.rd_en;
      res_valid_o <= cmd_i.vblend;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSourceWidth:  sw_reg_q <= cfg_data_i[6:0];
          RegSourceHeight: sh_reg_q <= cfg_data_i[6:0];
          RegTargetWidth:  tw_reg_q <= cfg_data_i[12:0];
          RegTargetHeight: th_reg_q <= cfg_data_i[12:0];
          RegStepX:        stx_q <= cfg_data_i;
          RegStepY:        sty_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        load_ptr_q <= ptr_n;
      end
      if (cmd_i.map) begin
        if (rend) begin
          col_q <= '0;
          xpos_q <= -33'sd32768;
          if (fend) begin
            row_q <= '0; ypos_q <= -33'sd32768;
          end else begin
            row_q <= row_q + 12'd1;
            ypos_q <= (ypos_q + $signed({11'd0, sty_q}) > 33'sd2147483647) ?
                      33'sd2147483647 : ypos_q + $signed({11'd0, sty_q});
          end
        end else begin
          col_q <= col_q + 12'd1;
          xpos_q <= (xpos_q + $signed({11'd0, stx_q}) > 33'sd2147483647) ?
                    33'sd2147483647 : xpos_q + $signed({11'd0, stx_q});
        end
      end
    end
  end
endmodule

@@ sv/bilinear_image_upscaler.sv @@
// Top level of the bilinear image upscaler.
// A load command stores one source pixel. An emit command runs through four reads of the
// frame store, a horizontal and a vertical blend stage; its result word then appears
// with out_valid_o high for one cycle, and the next command may start in that same
// cycle. The receiver cannot stall results.
module bilinear_image_upscaler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  biu_pkg::in_word_t            in_word_i,
  output logic                         out_valid_o,
  output biu_pkg::out_word_t           out_word_o,
  input  logic                         cfg_we_i,
  input  logic [biu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [biu_pkg::CfgDataW-1:0] cfg_data_i
);
  import biu_pkg::*;

  cmd_t cmd;

  biu_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .opcode_i(in_word_i.opcode),
    .busy(busy), .cmd_o(cmd)
  );

  biu_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .in_i(in_word_i),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .res_valid_o(out_valid_o), .res_o(out_word_o)
  );
endmodule

@@ sv/biu_checker.sv @@
// Port-level checker for the bilinear image upscaler and its binding.
module biu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic out_valid_o,
  input logic frame_end,
  input logic row_end
);
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy)) else $error("result without busy");
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end) |-> row_end) else $error("frame end without row end");
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o) else $error("back-to-back results");
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy) else $error("busy with result");
endmodule

bind bilinear_image_upscaler biu_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .out_valid_o(out_valid_o), .frame_end(out_word_o.frame_end),
  .row_end(out_word_o.row_end)
);
